[rtl/tli_pkg.sv]
// ----------------------------------------------------------------------------
// tli_pkg: shared types and constants of the interpolation table
// Controller states, datapath command and status words, register indexes
// and the fixed field widths of the block.
// ----------------------------------------------------------------------------
package tli_pkg;

    localparam int DATA_W        = 32;
    localparam int INDEX_W       = 6;
    localparam int ENTRY_COUNT_W = 7;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 7;

    localparam logic [ENTRY_COUNT_W-1:0] ENTRY_COUNT_RESET = 7'd2;

    localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

    // Operation codes of the op field.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_READY = 1'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH_FIRST,
        ST_FETCH_LAST,
        ST_LOAD_LAST,
        ST_CHECK_ENDS,
        ST_SEARCH_READ,
        ST_SEARCH_CMP,
        ST_DIV_SETUP,
        ST_DIVIDE,
        ST_MULTIPLY,
        ST_ACCUM,
        ST_DELIVER
    } tli_state_t;

    typedef enum logic [1:0] {
        RD_FIRST,
        RD_LAST,
        RD_MID
    } rd_sel_t;

    typedef enum logic [2:0] {
        RES_NOT_READY,
        RES_BELOW,
        RES_ABOVE,
        RES_LOWER,
        RES_INTERP
    } res_sel_t;

    typedef struct packed {
        logic     write_entry;
        logic     latch_query;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     init_lo;
        logic     init_hi;
        logic     search_step;
        logic     div_setup;
        logic     div_step;
        logic     mult;
        logic     load_result;
        res_sel_t res_sel;
        logic     out_load;
    } tli_cmd_t;

    typedef struct packed {
        logic table_ready;
        logic below;
        logic above;
        logic span_gt1;
        logic gap_pos;
        logic div_last;
        logic out_free;
    } tli_status_t;

endpackage

[rtl/table_linear_interpolator_unit.sv]
// A query on a table not marked ready is answered without reading the table,
// one outside the breakpoint range after the end checks, and an interior one
// after the binary search and, unless the gap is zero, division and multiply.
// A write word is stored on acceptance; a query holds the input until its
// result is in the output register, set by the single table read port and the
// bit-serial divider. Reset clears control and configuration, not the table.
// ----------------------------------------------------------------------------
// table_linear_interpolator_unit: one-dimensional interpolation table
// Loads breakpoint/value pairs and answers queries by binary search and
// linear interpolation in signed fixed point, clamping outside the range.
// ----------------------------------------------------------------------------
module table_linear_interpolator_unit
#(
    parameter int MAX_ENTRIES   = 64,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [tli_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tli_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 op,
    input  logic [tli_pkg::INDEX_W-1:0]          entry_index,
    input  logic signed [tli_pkg::DATA_W-1:0]    point_x,
    input  logic signed [tli_pkg::DATA_W-1:0]    point_y,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [tli_pkg::DATA_W-1:0]    result_value,
    output logic                                 below_range,
    output logic                                 above_range,
    output logic                                 not_ready
);

    tli_pkg::tli_cmd_t    cmd;
    tli_pkg::tli_status_t status;

    tli_controller u_controller
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tli_datapath
    #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .FRACTION_BITS (FRACTION_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .entry_index  (entry_index),
        .point_x      (point_x),
        .point_y      (point_y),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .result_value (result_value),
        .below_range  (below_range),
        .above_range  (above_range),
        .not_ready    (not_ready)
    );

endmodule

[rtl/tli_controller.sv]
// ----------------------------------------------------------------------------
// tli_controller: sequencer of the interpolation table
// Steps one query through end checks, binary search, division, multiply
// and delivery, and issues table writes.
// ----------------------------------------------------------------------------
module tli_controller
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                op,
    output logic                in_ready,
    input  tli_pkg::tli_status_t status,
    output tli_pkg::tli_cmd_t   cmd
);

    tli_pkg::tli_state_t state_reg;
    tli_pkg::tli_state_t state_next;
    logic                accept;

    assign in_ready = (state_reg == tli_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tli_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tli_pkg::ST_IDLE:
            begin
                if (accept && (op == tli_pkg::OP_QUERY))
                begin
                    state_next = status.table_ready ? tli_pkg::ST_FETCH_FIRST
                                                    : tli_pkg::ST_DELIVER;
                end
            end
            tli_pkg::ST_FETCH_FIRST: state_next = tli_pkg::ST_FETCH_LAST;
            tli_pkg::ST_FETCH_LAST:  state_next = tli_pkg::ST_LOAD_LAST;
            tli_pkg::ST_LOAD_LAST:   state_next = tli_pkg::ST_CHECK_ENDS;
            tli_pkg::ST_CHECK_ENDS:
            begin
                if (status.below || status.above)
                begin
                    state_next = tli_pkg::ST_DELIVER;
                end
                else
                begin
                    state_next = tli_pkg::ST_SEARCH_READ;
                end
            end
            tli_pkg::ST_SEARCH_READ:
            begin
                state_next = status.span_gt1 ? tli_pkg::ST_SEARCH_CMP
                                             : tli_pkg::ST_DIV_SETUP;
            end
            tli_pkg::ST_SEARCH_CMP: state_next = tli_pkg::ST_SEARCH_READ;
            tli_pkg::ST_DIV_SETUP:
            begin
                state_next = status.gap_pos ? tli_pkg::ST_DIVIDE : tli_pkg::ST_DELIVER;
            end
            tli_pkg::ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = tli_pkg::ST_MULTIPLY;
                end
            end
            tli_pkg::ST_MULTIPLY: state_next = tli_pkg::ST_ACCUM;
            tli_pkg::ST_ACCUM:    state_next = tli_pkg::ST_DELIVER;
            tli_pkg::ST_DELIVER:
            begin
                if (status.out_free)
                begin
                    state_next = tli_pkg::ST_IDLE;
                end
            end
            default: state_next = tli_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            tli_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == tli_pkg::OP_WRITE)
                    begin
                        cmd.write_entry = 1'b1;
                    end
                    else if (status.table_ready)
                    begin
                        cmd.latch_query = 1'b1;
                    end
                    else
                    begin
                        cmd.load_result = 1'b1;
                        cmd.res_sel     = tli_pkg::RES_NOT_READY;
                    end
                end
            end
            tli_pkg::ST_FETCH_FIRST:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = tli_pkg::RD_FIRST;
            end
            tli_pkg::ST_FETCH_LAST:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = tli_pkg::RD_LAST;
                cmd.init_lo = 1'b1;
            end
            tli_pkg::ST_LOAD_LAST:
            begin
                cmd.init_hi = 1'b1;
            end
            tli_pkg::ST_CHECK_ENDS:
            begin
                if (status.below)
                begin
                    cmd.load_result = 1'b1;
                    cmd.res_sel     = tli_pkg::RES_BELOW;
                end
                else if (status.above)
                begin
                    cmd.load_result = 1'b1;
                    cmd.res_sel     = tli_pkg::RES_ABOVE;
                end
            end
            tli_pkg::ST_SEARCH_READ:
            begin
                if (status.span_gt1)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = tli_pkg::RD_MID;
                end
            end
            tli_pkg::ST_SEARCH_CMP:
            begin
                cmd.search_step = 1'b1;
            end
            tli_pkg::ST_DIV_SETUP:
            begin
                if (status.gap_pos)
                begin
                    cmd.div_setup = 1'b1;
                end
                else
                begin
                    cmd.load_result = 1'b1;
                    cmd.res_sel     = tli_pkg::RES_LOWER;
                end
            end
            tli_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            tli_pkg::ST_MULTIPLY:
            begin
                cmd.mult = 1'b1;
            end
            tli_pkg::ST_ACCUM:
            begin
                cmd.load_result = 1'b1;
                cmd.res_sel     = tli_pkg::RES_INTERP;
            end
            tli_pkg::ST_DELIVER:
            begin
                cmd.out_load = status.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

[rtl/tli_datapath.sv]
// ----------------------------------------------------------------------------
// tli_datapath: table memory and arithmetic of the interpolation table
// Holds the configuration registers, the breakpoint/value memory, the search
// bounds, a restoring divider, the multiplier and the output register.
// ----------------------------------------------------------------------------
module tli_datapath
#(
    parameter int MAX_ENTRIES   = 64,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [tli_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tli_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [tli_pkg::INDEX_W-1:0]          entry_index,
    input  logic signed [tli_pkg::DATA_W-1:0]    point_x,
    input  logic signed [tli_pkg::DATA_W-1:0]    point_y,
    input  tli_pkg::tli_cmd_t                    cmd,
    output tli_pkg::tli_status_t                 status,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic signed [tli_pkg::DATA_W-1:0]    result_value,
    output logic                                 below_range,
    output logic                                 above_range,
    output logic                                 not_ready
);

    localparam int AW  = $clog2(MAX_ENTRIES);
    localparam int QW  = FRACTION_BITS + 1;
    localparam int CW  = $clog2(FRACTION_BITS + 1);
    localparam int PW  = FRACTION_BITS + 35;
    localparam int DW  = tli_pkg::DATA_W;

    // Configuration registers.
    logic [tli_pkg::ENTRY_COUNT_W-1:0] entry_count_reg;
    logic                              table_ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= tli_pkg::ENTRY_COUNT_RESET;
            table_ready_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tli_pkg::REG_ENTRY_COUNT: entry_count_reg <= cfg_data;
                tli_pkg::REG_TABLE_READY: table_ready_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Entry count clamped to 2..MAX_ENTRIES, then the index of the last entry.
    logic [AW:0]   count_clamped;
    logic [AW-1:0] last_idx;

    always_comb
    begin
        if (32'(entry_count_reg) >= 32'(MAX_ENTRIES))
        begin
            count_clamped = (AW+1)'(MAX_ENTRIES);
        end
        else if (entry_count_reg < tli_pkg::ENTRY_COUNT_W'(2))
        begin
            count_clamped = (AW+1)'(2);
        end
        else
        begin
            count_clamped = (AW+1)'(entry_count_reg);
        end
    end

    assign last_idx = AW'(count_clamped - (AW+1)'(1));

    // Table memory: breakpoint in the upper half of a word, value in the lower.
    logic [2*DW-1:0] table_mem [MAX_ENTRIES];
    logic [2*DW-1:0] rd_data_reg;
    logic [31:0]     wr_index_ext;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    logic signed [DW-1:0] rd_bp;
    logic signed [DW-1:0] rd_val;

    assign wr_index_ext = 32'(entry_index);
    assign wr_addr      = wr_index_ext[AW-1:0];
    assign rd_bp        = rd_data_reg[2*DW-1:DW];
    assign rd_val       = rd_data_reg[DW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.write_entry && (wr_index_ext < 32'(MAX_ENTRIES)))
        begin
            table_mem[wr_addr] <= {point_x, point_y};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    // Search bounds and the entries they point at.
    logic signed [DW-1:0] x_reg;
    logic [AW-1:0]        lo_idx_reg;
    logic [AW-1:0]        hi_idx_reg;
    logic signed [DW-1:0] lo_bp_reg;
    logic signed [DW-1:0] lo_val_reg;
    logic signed [DW-1:0] hi_bp_reg;
    logic signed [DW-1:0] hi_val_reg;
    logic [AW:0]          idx_sum;
    logic [AW-1:0]        mid_idx;

    assign idx_sum = {1'b0, lo_idx_reg} + {1'b0, hi_idx_reg};
    assign mid_idx = AW'(idx_sum >> 1);

    always_comb
    begin
        case (cmd.rd_sel)
            tli_pkg::RD_FIRST: rd_addr = '0;
            tli_pkg::RD_LAST:  rd_addr = last_idx;
            tli_pkg::RD_MID:   rd_addr = mid_idx;
            default:           rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_query)
        begin
            x_reg <= point_x;
        end
        if (cmd.init_lo)
        begin
            lo_idx_reg <= '0;
            lo_bp_reg  <= rd_bp;
            lo_val_reg <= rd_val;
        end
        if (cmd.init_hi)
        begin
            hi_idx_reg <= last_idx;
            hi_bp_reg  <= rd_bp;
            hi_val_reg <= rd_val;
        end
        if (cmd.search_step)
        begin
            if (x_reg >= rd_bp)
            begin
                lo_idx_reg <= mid_idx;
                lo_bp_reg  <= rd_bp;
                lo_val_reg <= rd_val;
            end
            else
            begin
                hi_idx_reg <= mid_idx;
                hi_bp_reg  <= rd_bp;
                hi_val_reg <= rd_val;
            end
        end
    end

    // Gap and offset from the lower breakpoint, both 33-bit signed.
    logic signed [DW:0] gap;
    logic signed [DW:0] dx;
    logic signed [DW:0] dx_clamped;

    assign gap = {hi_bp_reg[DW-1], hi_bp_reg} - {lo_bp_reg[DW-1], lo_bp_reg};
    assign dx  = {x_reg[DW-1], x_reg} - {lo_bp_reg[DW-1], lo_bp_reg};

    always_comb
    begin
        if (dx[DW])
        begin
            dx_clamped = '0;
        end
        else if (dx > gap)
        begin
            dx_clamped = gap;
        end
        else
        begin
            dx_clamped = dx;
        end
    end

    // Restoring divider, one quotient bit a cycle, most significant first.
    // The first step decides the integer bit, since the offset never exceeds
    // the gap.
    logic [DW:0]   rem_reg;
    logic [DW-1:0] gap_reg;
    logic [QW-1:0] quot_reg;
    logic [CW-1:0] div_cnt_reg;
    logic          trial;
    logic [DW-1:0] rem_sub;

    // What is left after a step is always below the gap, so it fits in DW bits.
    assign trial   = (rem_reg >= {1'b0, gap_reg});
    assign rem_sub = trial ? DW'(rem_reg - {1'b0, gap_reg}) : rem_reg[DW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.div_setup)
        begin
            rem_reg     <= dx_clamped;
            gap_reg     <= gap[DW-1:0];
            quot_reg    <= '0;
            div_cnt_reg <= CW'(FRACTION_BITS);
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= {rem_sub, 1'b0};
            quot_reg    <= {quot_reg[QW-2:0], trial};
            div_cnt_reg <= div_cnt_reg - CW'(1);
        end
    end

    // Multiply the fraction by the value gap; the arithmetic shift gives the
    // rounding towards minus infinity.
    logic signed [QW:0]   frac_s;
    logic signed [DW:0]   dy;
    logic signed [PW-1:0] prod_full;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_shifted;
    logic signed [PW-1:0] sum;
    logic signed [DW-1:0] sum_sat;

    assign frac_s       = $signed({1'b0, quot_reg});
    assign dy           = {hi_val_reg[DW-1], hi_val_reg} - {lo_val_reg[DW-1], lo_val_reg};
    assign prod_full    = frac_s * dy;
    assign prod_shifted = prod_reg >>> FRACTION_BITS;
    assign sum          = prod_shifted + PW'(lo_val_reg);

    always_comb
    begin
        if (sum > PW'(tli_pkg::DATA_MAX))
        begin
            sum_sat = tli_pkg::DATA_MAX;
        end
        else if (sum < PW'(tli_pkg::DATA_MIN))
        begin
            sum_sat = tli_pkg::DATA_MIN;
        end
        else
        begin
            sum_sat = sum[DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mult)
        begin
            prod_reg <= prod_full;
        end
    end

    // Result held until the output register is free.
    logic signed [DW-1:0] res_value_reg;
    logic                 res_below_reg;
    logic                 res_above_reg;
    logic                 res_nr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            res_below_reg <= 1'b0;
            res_above_reg <= 1'b0;
            res_nr_reg    <= 1'b0;
            case (cmd.res_sel)
                tli_pkg::RES_NOT_READY:
                begin
                    res_value_reg <= '0;
                    res_nr_reg    <= 1'b1;
                end
                tli_pkg::RES_BELOW:
                begin
                    res_value_reg <= lo_val_reg;
                    res_below_reg <= 1'b1;
                end
                tli_pkg::RES_ABOVE:
                begin
                    res_value_reg <= hi_val_reg;
                    res_above_reg <= 1'b1;
                end
                tli_pkg::RES_LOWER:  res_value_reg <= lo_val_reg;
                tli_pkg::RES_INTERP: res_value_reg <= sum_sat;
                default:             res_value_reg <= '0;
            endcase
        end
    end

    // Output register.
    logic                 out_valid_reg;
    logic signed [DW-1:0] out_value_reg;
    logic                 out_below_reg;
    logic                 out_above_reg;
    logic                 out_nr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_value_reg <= res_value_reg;
            out_below_reg <= res_below_reg;
            out_above_reg <= res_above_reg;
            out_nr_reg    <= res_nr_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign below_range  = out_below_reg;
    assign above_range  = out_above_reg;
    assign not_ready    = out_nr_reg;

    assign status.table_ready = table_ready_reg;
    assign status.below       = (x_reg < lo_bp_reg);
    assign status.above       = (x_reg > hi_bp_reg);
    assign status.span_gt1    = ((hi_idx_reg - lo_idx_reg) > AW'(1));
    assign status.gap_pos     = !gap[DW] && (gap != '0);
    assign status.div_last    = (div_cnt_reg == '0);
    assign status.out_free    = !out_valid_reg || out_ready;

`ifndef NO_ASSERTIONS
    // The bracket never collapses or inverts during the search.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.search_step |=> (lo_idx_reg < hi_idx_reg))
        else $error("search bracket collapsed");

    // The partial remainder stays below twice the gap on every division step.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < {gap_reg, 1'b0}))
        else $error("divider remainder out of range");

    // The fraction never exceeds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mult |-> (quot_reg <= (QW'(1) << FRACTION_BITS)))
        else $error("interpolation fraction above one");

    // A word is never written over one that has not yet been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten");
`endif

endmodule

[sim/tb_table_linear_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// tb_table_linear_interpolator_unit: self-checking bench for the table unit
// Loads sorted and scrambled tables, sweeps the entry count and ready flag
// through their extremes and checks every query result against a local
// model of the binary search and the fixed point interpolation, with random
// idling on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_table_linear_interpolator_unit;

    localparam int TABLE_DEPTH   = 64;
    localparam int FRAC_BITS     = 16;
    localparam int SETTLE_CYCLES = 48;
    localparam int STALL_LIMIT   = 2000;
    localparam int TARGET_WORDS  = 1350;
    localparam int REPORT_LIMIT  = 10;

    localparam logic signed [tli_pkg::DATA_W-1:0] ONE = 32'sh0001_0000;

    typedef struct packed {
        logic signed [tli_pkg::DATA_W-1:0] value;
        logic                              below;
        logic                              above;
        logic                              not_ready;
    } interp_result_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 cfg_write;
    logic [tli_pkg::CFG_INDEX_W-1:0]      cfg_index;
    logic [tli_pkg::CFG_DATA_W-1:0]       cfg_data;
    logic                                 in_valid;
    logic                                 in_ready;
    logic                                 op;
    logic [tli_pkg::INDEX_W-1:0]          entry_index;
    logic signed [tli_pkg::DATA_W-1:0]    point_x;
    logic signed [tli_pkg::DATA_W-1:0]    point_y;
    logic                                 out_valid;
    logic                                 out_ready;
    logic signed [tli_pkg::DATA_W-1:0]    result_value;
    logic                                 below_range;
    logic                                 above_range;
    logic                                 not_ready;

    // Local copy of the table and of the two registers.
    logic signed [tli_pkg::DATA_W-1:0]    bp_model    [TABLE_DEPTH];
    logic signed [tli_pkg::DATA_W-1:0]    value_model [TABLE_DEPTH];
    logic [tli_pkg::ENTRY_COUNT_W-1:0]    count_model;
    logic                                 ready_model;

    interp_result_t                       expected_results [$];

    int mismatches;
    int words_sent;
    int sender_idle_pct;
    int receiver_stall_pct;
    int quiet_cycles;
    int phase;

    table_linear_interpolator_unit
    #(
        .MAX_ENTRIES   (TABLE_DEPTH),
        .FRACTION_BITS (FRAC_BITS)
    )
    i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .entry_index  (entry_index),
        .point_x      (point_x),
        .point_y      (point_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .below_range  (below_range),
        .above_range  (above_range),
        .not_ready    (not_ready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic signed [tli_pkg::DATA_W-1:0] clip32(longint v);
        if (v > longint'(tli_pkg::DATA_MAX))
        begin
            return tli_pkg::DATA_MAX;
        end
        if (v < longint'(tli_pkg::DATA_MIN))
        begin
            return tli_pkg::DATA_MIN;
        end
        return tli_pkg::DATA_W'(v);
    endfunction

    function automatic int used_entries();
        if (count_model < 2)
        begin
            return 2;
        end
        if (count_model > TABLE_DEPTH)
        begin
            return TABLE_DEPTH;
        end
        return int'(count_model);
    endfunction

    function automatic interp_result_t interpolate_at(logic signed [tli_pkg::DATA_W-1:0] x);
        interp_result_t r;
        int             n;
        int             lo;
        int             hi;
        int             mid;
        longint         gap;
        longint         dx;
        longint         dy;
        longint         frac;
        longint         prod;

        r = '0;
        if (!ready_model)
        begin
            r.not_ready = 1'b1;
            return r;
        end
        n = used_entries();
        if (x < bp_model[0])
        begin
            r.below = 1'b1;
            r.value = value_model[0];
            return r;
        end
        if (x > bp_model[n-1])
        begin
            r.above = 1'b1;
            r.value = value_model[n-1];
            return r;
        end
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) / 2;
            if (x >= bp_model[mid])
            begin
                lo = mid;
            end
            else
            begin
                hi = mid;
            end
        end
        gap = longint'(bp_model[hi]) - longint'(bp_model[lo]);
        if (gap <= 0)
        begin
            r.value = value_model[lo];
            return r;
        end
        dx = longint'(x) - longint'(bp_model[lo]);
        if (dx < 0)
        begin
            dx = 0;
        end
        if (dx > gap)
        begin
            dx = gap;
        end
        frac = (dx <<< FRAC_BITS) / gap;
        dy   = longint'(value_model[hi]) - longint'(value_model[lo]);
        prod = frac * dy;
        // An arithmetic shift of the signed product rounds toward minus infinity.
        r.value = clip32(longint'(value_model[lo]) + (prod >>> FRAC_BITS));
        return r;
    endfunction

    function automatic logic signed [tli_pkg::DATA_W-1:0] random_value();
        case ($urandom_range(7))
            0:       return tli_pkg::DATA_MIN;
            1:       return tli_pkg::DATA_MAX;
            2, 3:    return $signed($urandom_range(1048575)) - 524288;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [tli_pkg::DATA_W-1:0] pick_query_point(int n);
        int     k;
        longint lo_bp;
        longint span;

        k     = $urandom_range(n - 2);
        lo_bp = longint'(bp_model[k]);
        span  = longint'(bp_model[k+1]) - lo_bp;
        case ($urandom_range(9))
            0:       return bp_model[k];
            1:       return bp_model[k+1];
            2:       return clip32(longint'(bp_model[0]) + $signed($urandom_range(6)) - 3);
            3:       return clip32(longint'(bp_model[n-1]) + $signed($urandom_range(6)) - 3);
            4:       return $urandom;
            5:       return $urandom_range(1) ? tli_pkg::DATA_MIN : tli_pkg::DATA_MAX;
            default:
            begin
                if (span > 0)
                begin
                    return clip32(lo_bp + longint'({$urandom, $urandom} % span));
                end
                return bp_model[k];
            end
        endcase
    endfunction

    // Offers one word and holds it until taken. Valid is left high on return;
    // whoever sends nothing next lowers it in the same time step.
    task automatic send_word(logic op_code, logic [tli_pkg::INDEX_W-1:0] idx,
                             logic signed [tli_pkg::DATA_W-1:0] x,
                             logic signed [tli_pkg::DATA_W-1:0] y);
        int gap;

        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= op_code;
        entry_index <= idx;
        point_x     <= x;
        point_y     <= y;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        if (op_code == tli_pkg::OP_WRITE)
        begin
            bp_model[idx]    = x;
            value_model[idx] = y;
        end
        else
        begin
            expected_results.push_back(interpolate_at(x));
        end
        words_sent++;
    endtask

    // Waits for every outstanding result, then idles the input so that a register
    // write lands well clear of the last word.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(logic [tli_pkg::CFG_INDEX_W-1:0] idx,
                                logic [tli_pkg::CFG_DATA_W-1:0] data);
        drain_results();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == tli_pkg::REG_ENTRY_COUNT)
        begin
            count_model = data;
        end
        else
        begin
            ready_model = data[0];
        end
    endtask

    task automatic load_sorted_table(int n);
        longint step_max;
        longint room;
        longint point;

        case ($urandom_range(2))
            0:       step_max = 16;
            1:       step_max = 4 * 65536;
            default: step_max = 64'hFFFF_FFFF / n;
        endcase
        room  = 64'hFFFF_FFFF - step_max * n;
        point = longint'(tli_pkg::DATA_MIN) + longint'({$urandom, $urandom} % (room + 1));
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
            begin
                point = point + $urandom_range(1, step_max);
            end
            send_word(tli_pkg::OP_WRITE, tli_pkg::INDEX_W'(i), tli_pkg::DATA_W'(point),
                      random_value());
        end
    endtask

    task automatic test_not_ready();
        // Nothing is loaded yet, so only queries that never touch the table are sent.
        send_word(tli_pkg::OP_QUERY, '0, tli_pkg::DATA_MIN, tli_pkg::DATA_MAX);
        send_word(tli_pkg::OP_QUERY, '1, tli_pkg::DATA_MAX, tli_pkg::DATA_MIN);
        send_word(tli_pkg::OP_QUERY, 6'd17, '0, '0);
    endtask

    task automatic test_full_table();
        set_register(tli_pkg::REG_ENTRY_COUNT, 7'd64);
        load_sorted_table(TABLE_DEPTH);
        set_register(tli_pkg::REG_TABLE_READY, {6'($urandom), 1'b1});
        sender_idle_pct    = 35;
        receiver_stall_pct = 35;
        repeat (40)
        begin
            send_word(tli_pkg::OP_QUERY, 6'($urandom), pick_query_point(TABLE_DEPTH),
                      random_value());
        end
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
    endtask

    task automatic test_edge_cases();
        // A steep falling segment checks rounding of negative products.
        set_register(tli_pkg::REG_ENTRY_COUNT, 7'd4);
        send_word(tli_pkg::OP_WRITE, 6'd0, -ONE, tli_pkg::DATA_MIN);
        send_word(tli_pkg::OP_WRITE, 6'd1, '0, tli_pkg::DATA_MAX);
        send_word(tli_pkg::OP_WRITE, 6'd2, ONE, '0);
        send_word(tli_pkg::OP_WRITE, 6'd3, 3 * ONE, -32'sd5);
        send_word(tli_pkg::OP_QUERY, 6'd0, -2 * ONE, '0);
        send_word(tli_pkg::OP_QUERY, 6'd0, -ONE, '0);
        send_word(tli_pkg::OP_QUERY, 6'd0, 3 * ONE, '0);
        send_word(tli_pkg::OP_QUERY, 6'd0, 3 * ONE + 1, '0);
        send_word(tli_pkg::OP_QUERY, 6'd0, tli_pkg::DATA_MIN, '0);
        send_word(tli_pkg::OP_QUERY, 6'd0, tli_pkg::DATA_MAX, '0);
        send_word(tli_pkg::OP_QUERY, 6'd0, 32'sd1, '0);
        send_word(tli_pkg::OP_QUERY, 6'd0, -32'sd32768, '0);
        send_word(tli_pkg::OP_QUERY, 6'd0, 2 * ONE + 7, '0);
        // Two entries spanning the whole number range; a count below two acts as two.
        set_register(tli_pkg::REG_ENTRY_COUNT, 7'd0);
        send_word(tli_pkg::OP_WRITE, 6'd0, tli_pkg::DATA_MIN, tli_pkg::DATA_MIN);
        send_word(tli_pkg::OP_WRITE, 6'd1, tli_pkg::DATA_MAX, tli_pkg::DATA_MAX);
        send_word(tli_pkg::OP_QUERY, 6'd63, '0, '1);
        send_word(tli_pkg::OP_QUERY, 6'd63, tli_pkg::DATA_MIN, '1);
        send_word(tli_pkg::OP_QUERY, 6'd63, tli_pkg::DATA_MAX, '1);
        // Equal breakpoints leave a zero gap, which returns the lower value.
        set_register(tli_pkg::REG_ENTRY_COUNT, 7'd1);
        send_word(tli_pkg::OP_WRITE, 6'd0, ONE, 32'sd5);
        send_word(tli_pkg::OP_WRITE, 6'd1, ONE, 32'sd9);
        send_word(tli_pkg::OP_QUERY, 6'd0, ONE, '0);
        // A count above the table size acts as the full table, now out of order.
        set_register(tli_pkg::REG_ENTRY_COUNT, 7'd127);
        send_word(tli_pkg::OP_QUERY, 6'd0, tli_pkg::DATA_MAX, '0);
        send_word(tli_pkg::OP_QUERY, 6'd0, ONE, '0);
        set_register(tli_pkg::REG_TABLE_READY, 7'h7E);
        send_word(tli_pkg::OP_QUERY, 6'd0, '0, '0);
        set_register(tli_pkg::REG_TABLE_READY, 7'h01);
    endtask

    task automatic run_random_phase(int phase_no);
        int n;
        int count_code;

        case (phase_no % 4)
            0:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            1:
            begin
                sender_idle_pct    = 87;
                receiver_stall_pct = 0;
            end
            2:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 87;
            end
            default:
            begin
                sender_idle_pct    = 35;
                receiver_stall_pct = 35;
            end
        endcase

        if ($urandom_range(9) < 7)
        begin
            // Small tables are the common case; the odd one is large or out of range.
            case ($urandom_range(9))
                0:       count_code = $urandom_range(1);
                1:       count_code = $urandom_range(65, 127);
                2:       count_code = $urandom_range(9, 64);
                default: count_code = $urandom_range(2, 8);
            endcase
            set_register(tli_pkg::REG_ENTRY_COUNT, 7'(count_code));
            n = used_entries();
            if ($urandom_range(3) == 0)
            begin
                set_register(tli_pkg::REG_TABLE_READY, {6'($urandom), 1'b0});
            end
            load_sorted_table(n);
            set_register(tli_pkg::REG_TABLE_READY, {6'($urandom), ($urandom_range(7) != 0)});
            repeat ($urandom_range(10, 30))
            begin
                if ($urandom_range(19) == 0 && n < TABLE_DEPTH)
                begin
                    // Entries above the used ones leave the answers alone.
                    send_word(tli_pkg::OP_WRITE, 6'($urandom_range(n, TABLE_DEPTH - 1)),
                              $urandom, $urandom);
                end
                else if ($urandom_range(29) == 0)
                begin
                    drain_results();
                end
                else
                begin
                    send_word(tli_pkg::OP_QUERY, 6'($urandom), pick_query_point(n),
                              random_value());
                end
            end
        end
        else
        begin
            // Scrambled writes and queries leave the breakpoints out of order.
            repeat ($urandom_range(15, 40))
            begin
                send_word(1'($urandom), 6'($urandom), random_value(), random_value());
            end
        end
    endtask

    always @(posedge clk)
    begin : check_results
        interp_result_t want;

        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("unexpected result word: value %0d below %b above %b not_ready %b",
                             result_value, below_range, above_range, not_ready);
                end
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_value !== want.value || below_range !== want.below ||
                    above_range !== want.above || not_ready !== want.not_ready)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("result mismatch: expected value %0d below %b above %b %s %b",
                                 want.value, want.below, want.above, "not_ready",
                                 want.not_ready);
                        $display("                 actual   value %0d below %b above %b %s %b",
                                 result_value, below_range, above_range, "not_ready",
                                 not_ready);
                    end
                end
            end
        end
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Ends the run if neither side moves a word for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (rst_n)
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        in_valid           = 1'b0;
        op                 = tli_pkg::OP_WRITE;
        entry_index        = '0;
        point_x            = '0;
        point_y            = '0;
        out_ready          = 1'b0;
        mismatches         = 0;
        words_sent         = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        quiet_cycles       = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            bp_model[i]    = '0;
            value_model[i] = '0;
        end
        count_model = tli_pkg::ENTRY_COUNT_RESET;
        ready_model = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_not_ready();
        test_full_table();
        test_edge_cases();
        phase = 0;
        while (words_sent < TARGET_WORDS)
        begin
            run_random_phase(phase);
            phase++;
        end
        drain_results();

        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
